// ===== sv/sbl_pkg.sv =====
// sbl_pkg: shared types and constants for the sorted byte list
// holds request and status codes and the controller/datapath interface structs
// no dependencies
`default_nettype none

package sbl_pkg;

    // default number of stored values
    localparam int SBL_CAPACITY = 16;

    // request kinds carried on s_tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } sbl_status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic        load;        // latch request, init walk index
        logic        rd_en;       // read entry at walk address
        logic        wr_en;       // write entry at walk address
        logic        wr_val;      // write data is request value, else read data
        logic        idx_inc;
        logic        idx_dec;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        set_found;
        logic        set_status;
        sbl_status_t status;
        logic        out_load;    // move result into output register
    } sbl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_delete;
        logic full;
        logic empty;
        logic idx_zero;
        logic idx_end;
        logic rd_ge;
        logic rd_eq;
        logic found;
        logic out_free;
    } sbl_sts_t;

endpackage

`default_nettype wire

// ===== sv/sbl_ctrl.sv =====
// sbl_ctrl: request sequencer for the sorted byte list
// walks the entry memory one entry per read/compare pair
// depends on sbl_pkg
`default_nettype none

module sbl_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire sbl_pkg::sbl_sts_t sts,
    output sbl_pkg::sbl_cmd_t     cmd
);
    import sbl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // no request is taken while reset is held
    assign s_tready = aresetn && (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.status     = ST_INSERTED;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (!sts.is_delete) begin
                    // insert walks down from the top
                    if (sts.full) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FULL;
                        state_next     = S_FIN;
                    end else if (sts.idx_zero) begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_val     = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_INSERTED;
                        state_next     = S_FIN;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_CMP;
                    end
                end else begin
                    // delete walks up from the bottom
                    if (sts.empty) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_EMPTY;
                        state_next     = S_FIN;
                    end else if (sts.idx_end) begin
                        cmd.set_status = 1'b1;
                        if (sts.found) begin
                            cmd.cnt_dec = 1'b1;
                            cmd.status  = ST_DELETED;
                        end else begin
                            cmd.status  = ST_NOT_FOUND;
                        end
                        state_next = S_FIN;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (!sts.is_delete) begin
                    if (sts.rd_ge) begin
                        // shift entry up one slot
                        cmd.wr_en   = 1'b1;
                        cmd.idx_dec = 1'b1;
                        state_next  = S_RD;
                    end else begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_val     = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_INSERTED;
                        state_next     = S_FIN;
                    end
                end else begin
                    // after the match, shift entries down one slot
                    if (sts.found) begin
                        cmd.wr_en = 1'b1;
                    end else if (sts.rd_eq) begin
                        cmd.set_found = 1'b1;
                    end
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sbl_dpath.sv =====
// sbl_dpath: entry memory, count, walk index and result register
// executes the commands of sbl_ctrl
// depends on sbl_pkg
`default_nettype none

module sbl_dpath #(
    parameter int CAPACITY = sbl_pkg::SBL_CAPACITY
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_tdata,   // [7:0] value
    input  wire logic [0:0]        s_tuser,   // [0] req_type
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // [2:0] status, [7:3] entry_count, [8] is_empty
    input  wire sbl_pkg::sbl_cmd_t cmd,
    output sbl_pkg::sbl_sts_t      sts
);
    import sbl_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [7:0]       mem [CAPACITY];
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] rd_addr_w;
    logic [CNT_W-1:0] wr_addr_w;
    logic [7:0]       wr_data;
    logic [7:0]       value_reg;
    logic             req_reg;
    logic             found_reg;
    sbl_status_t      status_reg;
    logic             out_valid_reg;
    logic [15:0]      out_data_reg;
    logic [CNT_W+4:0] cnt_wide;

    assign idx_m1 = idx_reg - 1'b1;

    // insert reads below and writes at the index, delete the other way round
    assign rd_addr_w = (req_reg == REQ_DELETE) ? idx_reg : idx_m1;
    assign wr_addr_w = (req_reg == REQ_DELETE) ? idx_m1 : idx_reg;
    assign wr_data   = cmd.wr_val ? value_reg : rd_data_reg;

    // entry memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr_w[ADDR_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr_w[ADDR_W-1:0]];
        end
    end

    // request latch and walk index
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_tdata;
            req_reg   <= s_tuser[0];
            idx_reg   <= (s_tuser[0] == REQ_DELETE) ? '0 : count_reg;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_m1;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
    end

    // count and match flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.load) begin
                found_reg <= 1'b0;
            end else if (cmd.set_found) begin
                found_reg <= 1'b1;
            end
        end
    end

    // result register
    assign cnt_wide = {5'd0, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {7'd0, (count_reg == '0), cnt_wide[4:0], status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // status to controller
    always_comb begin
        sts.is_delete = (req_reg == REQ_DELETE);
        sts.full      = (count_reg == CNT_W'(CAPACITY));
        sts.empty     = (count_reg == '0);
        sts.idx_zero  = (idx_reg == '0);
        sts.idx_end   = (idx_reg == count_reg);
        sts.rd_ge     = (rd_data_reg >= value_reg);
        sts.rd_eq     = (rd_data_reg == value_reg);
        sts.found     = found_reg;
        sts.out_free  = !out_valid_reg || m_tready;
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (wr_addr_w < CNT_W'(CAPACITY)))
        else $error("write beyond entry store");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before taken");

    a_cnt_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not advance on insert");

endmodule

`default_nettype wire

// ===== sv/sorted_byte_list.sv =====
// sorted_byte_list: top level of the sorted byte store
// joins sbl_ctrl and sbl_dpath; depends on sbl_pkg
//
//  channel  dir  tdata                                        tuser
//  s_       in   [7:0] value                                  [0] req_type
//  m_       out  [2:0] status, [7:3] entry_count, [8] empty   -
//
// insert reads and compares each stored value not smaller than the value, moving it up,
// then writes the value; a full list is refused without a walk
// delete reads and compares every stored value, shifting those after the match down
// the walk goes over the single entry memory with registered read
// aresetn clears the count and the controller; stored entries are not cleared
// a new request is taken while the last result waits in the output register
`default_nettype none

module sorted_byte_list #(
    parameter int CAPACITY = sbl_pkg::SBL_CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] value
    input  wire logic [0:0]  s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [2:0] status, [7:3] entry_count, [8] is_empty
);
    import sbl_pkg::*;

    sbl_cmd_t cmd;
    sbl_sts_t sts;

    // sequencer
    sbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and result
    sbl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire
